// ===== design/sparse_conv_gather_scatter_top_macros.svh =====
// Assertion macros for the sparse conv gather/scatter block.
// Included by scgs_back, the RTL file that carries concurrent assertions.
`ifndef SPARSE_CONV_GATHER_SCATTER_TOP_MACROS_SVH
`define SPARSE_CONV_GATHER_SCATTER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define SCGS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true out of reset
`define SCGS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SCGS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCGS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== design/scgs_pkg.sv =====
// Shared types and constants for the sparse conv gather/scatter block.
// No dependencies.
`default_nettype none
package scgs_pkg;

  localparam int SITES_DEF    = 256;
  localparam int CHANNELS_DEF = 64;
  localparam int MAX_ADDR_W   = 22;  // 65536 sites x 64 channels
  localparam int VAL_W        = 32;
  localparam int CH_W         = 6;
  localparam int SITE_W       = 8;
  localparam int MODE_W       = 3;
  localparam int CFG_W        = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
  localparam int RES_DEPTH    = 4;
  localparam int RES_PW       = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GATHER  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCATTER = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_GATHER,
    OP_SCATTER,
    OP_READ,
    OP_CLEAR
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e                op;
    logic [MAX_ADDR_W-1:0]  addr;      // element address, or row base for gather
    logic                   zero;      // out-of-range read/gather: emit zeros
    logic [CH_W-1:0]        channel;
    logic [VAL_W-1:0]       value;
    logic [CH_W-1:0]        last_ch;
    logic                   list_end;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [CH_W-1:0]  channel;
    logic             row_last;
    logic             list_end;
  } res_t;

endpackage
`default_nettype wire

// ===== design/scgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module scgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/scgs_front.sv =====
// Front end: takes input items, range-checks and classifies them into
// commands, and holds them in a two-entry command queue. Uses scgs_pkg.
`default_nettype none
module scgs_front import scgs_pkg::*; #(
  parameter int SITES    = SITES_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [SITE_W-1:0] site_i,
  input  wire logic [CH_W-1:0]   channel_i,
  input  wire logic [VAL_W-1:0]  value_i,
  input  wire logic              batch_end_i,
  input  wire logic [CH_W-1:0]   last_ch_i,
  input  wire logic              hold_i,
  output logic                   cmd_valid_o,
  output cmd_t                   cmd_o,
  input  wire logic              cmd_pop_i
);

  logic       site_ok, elem_ok, want, accept, do_push;
  cmd_t       cmd_new;
  cmd_t       q_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign site_ok = 32'(site_i) < SITES;
  assign elem_ok = site_ok && (32'(channel_i) < CHANNELS);

  always_comb begin
    cmd_new          = '0;
    cmd_new.channel  = channel_i;
    cmd_new.value    = value_i;
    cmd_new.last_ch  = last_ch_i;
    cmd_new.list_end = batch_end_i;
    want             = 1'b0;
    unique case (mode_i)
      MODE_LOAD: begin
        cmd_new.op   = OP_LOAD;
        cmd_new.addr = MAX_ADDR_W'(32'(site_i) * CHANNELS + 32'(channel_i));
        want         = elem_ok;
      end
      MODE_GATHER: begin
        cmd_new.op   = OP_GATHER;
        cmd_new.addr = site_ok ? MAX_ADDR_W'(32'(site_i) * CHANNELS) : '0;
        cmd_new.zero = !site_ok;
        want         = 1'b1;
      end
      MODE_SCATTER: begin
        cmd_new.op   = OP_SCATTER;
        cmd_new.addr = MAX_ADDR_W'(32'(site_i) * CHANNELS + 32'(channel_i));
        want         = elem_ok;
      end
      MODE_READ: begin
        cmd_new.op   = OP_READ;
        cmd_new.addr = elem_ok ? MAX_ADDR_W'(32'(site_i) * CHANNELS + 32'(channel_i)) : '0;
        cmd_new.zero = !elem_ok;
        want         = 1'b1;
      end
      MODE_CLEAR: begin
        cmd_new.op = OP_CLEAR;
        want       = 1'b1;
      end
      default: begin
        want = 1'b0;  // unknown modes: item is taken and dropped
      end
    endcase
  end

  assign full_o      = (cnt_q == 2'd2) || hold_i;
  assign accept      = push_i && !full_o;
  assign do_push     = accept && want;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(cmd_pop_i);
    end
  end

endmodule
`default_nettype wire

// ===== design/scgs_back.sv =====
// Back end: sequencer over the feature and gradient RAMs, plus the
// result queue. Uses scgs_pkg, scgs_ram and the assertion macros.
`default_nettype none
`include "sparse_conv_gather_scatter_top_macros.svh"
module scgs_back import scgs_pkg::*; #(
  parameter int SITES    = SITES_DEF,
  parameter int CHANNELS = CHANNELS_DEF,
  localparam int DEPTH = SITES * CHANNELS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      init_busy_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output res_t      res_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_GATHER  = 3'd1;
  localparam logic [2:0] ST_SCAT_WB = 3'd2;
  localparam logic [2:0] ST_CLEAR   = 3'd3;

  function automatic logic [VAL_W-1:0] sat_add(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      sat_add = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      sat_add = s[VAL_W-1:0];
    end
  endfunction

  logic [2:0]       state_q, state_d;
  logic             init_q, init_d;
  logic [AW-1:0]    addr_q, addr_d;      // gather base or scatter address
  logic [AW-1:0]    clr_ptr_q, clr_ptr_d;
  logic [CH_W-1:0]  ch_q, ch_d;
  logic [CH_W-1:0]  last_ch_q, last_ch_d;
  logic             le_q, le_d, zero_q, zero_d;
  logic [VAL_W-1:0] val_q, val_d;

  // read in flight: the registered RAM data shows up in the cycle after issue
  logic             pend_q, pend_d;
  logic             pend_grad_q, pend_grad_d;
  logic             pend_zero_q, pend_zero_d;
  res_t             pend_meta_q, pend_meta_d;

  logic             feat_we, grad_we;
  logic [AW-1:0]    feat_raddr, grad_raddr, grad_waddr;
  logic [VAL_W-1:0] grad_wdata, feat_rdata, grad_rdata;

  res_t             res_q [RES_DEPTH];
  logic [RES_PW-1:0] rwr_q, rrd_q;
  logic [RES_PW:0]  oc_q;
  logic             space, res_push, res_pop;
  res_t             res_new;

  assign space = ({1'b0, oc_q} + (RES_PW+2)'(pend_q)) < (RES_PW+2)'(RES_DEPTH);

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    addr_d      = addr_q;
    clr_ptr_d   = clr_ptr_q;
    ch_d        = ch_q;
    last_ch_d   = last_ch_q;
    le_d        = le_q;
    zero_d      = zero_q;
    val_d       = val_q;
    pend_d      = 1'b0;
    pend_grad_d = pend_grad_q;
    pend_zero_d = pend_zero_q;
    pend_meta_d = pend_meta_q;
    cmd_pop_o   = 1'b0;
    feat_we     = 1'b0;
    grad_we     = 1'b0;
    feat_raddr  = addr_q + AW'(ch_q);
    grad_raddr  = cmd_i.addr[AW-1:0];
    grad_waddr  = addr_q;
    grad_wdata  = sat_add(grad_rdata, val_q);
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_LOAD: begin
              feat_we   = 1'b1;
              cmd_pop_o = 1'b1;
            end
            OP_SCATTER: begin
              addr_d    = cmd_i.addr[AW-1:0];
              val_d     = cmd_i.value;
              state_d   = ST_SCAT_WB;
              cmd_pop_o = 1'b1;
            end
            OP_READ: begin
              if (space) begin
                pend_d               = 1'b1;
                pend_grad_d          = 1'b1;
                pend_zero_d          = cmd_i.zero;
                pend_meta_d          = '0;
                pend_meta_d.channel  = cmd_i.channel;
                cmd_pop_o            = 1'b1;
              end
            end
            OP_GATHER: begin
              addr_d    = cmd_i.addr[AW-1:0];
              ch_d      = '0;
              last_ch_d = cmd_i.last_ch;
              le_d      = cmd_i.list_end;
              zero_d    = cmd_i.zero;
              state_d   = ST_GATHER;
              cmd_pop_o = 1'b1;
            end
            OP_CLEAR: begin
              clr_ptr_d = '0;
              state_d   = ST_CLEAR;
              cmd_pop_o = 1'b1;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_GATHER: begin
        if (space) begin
          pend_d               = 1'b1;
          pend_grad_d          = 1'b0;
          pend_zero_d          = zero_q;
          pend_meta_d          = '0;
          pend_meta_d.channel  = ch_q;
          pend_meta_d.row_last = (ch_q == last_ch_q);
          pend_meta_d.list_end = (ch_q == last_ch_q) && le_q;
          ch_d                 = ch_q + 1'b1;
          if (ch_q == last_ch_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCAT_WB: begin
        grad_we = 1'b1;
        state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        grad_we    = 1'b1;
        grad_waddr = clr_ptr_q;
        grad_wdata = '0;
        clr_ptr_d  = clr_ptr_q + 1'b1;
        if (clr_ptr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign init_busy_o = init_q;

  scgs_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (feat_we),
    .waddr_i (cmd_i.addr[AW-1:0]),
    .wdata_i (cmd_i.value),
    .raddr_i (feat_raddr),
    .rdata_o (feat_rdata)
  );

  scgs_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_grad_ram (
    .clk_i   (clk_i),
    .we_i    (grad_we),
    .waddr_i (grad_waddr),
    .wdata_i (grad_wdata),
    .raddr_i (grad_raddr),
    .rdata_o (grad_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;  // sweep the gradient store after reset
      init_q    <= 1'b1;
      clr_ptr_q <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      init_q    <= init_d;
      clr_ptr_q <= clr_ptr_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    ch_q        <= ch_d;
    last_ch_q   <= last_ch_d;
    le_q        <= le_d;
    zero_q      <= zero_d;
    val_q       <= val_d;
    pend_grad_q <= pend_grad_d;
    pend_zero_q <= pend_zero_d;
    pend_meta_q <= pend_meta_d;
  end

  // result queue
  always_comb begin
    res_new = pend_meta_q;
    if (pend_zero_q) begin
      res_new.value = '0;
    end else begin
      res_new.value = pend_grad_q ? grad_rdata : feat_rdata;
    end
  end

  assign res_push = pend_q;
  assign empty_o  = (oc_q == '0);
  assign res_pop  = pop_i && !empty_o;
  assign res_o    = res_q[rrd_q];

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[rwr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_q <= '0;
      rrd_q <= '0;
      oc_q  <= '0;
    end else begin
      if (res_push) begin
        rwr_q <= rwr_q + 1'b1;
      end
      if (res_pop) begin
        rrd_q <= rrd_q + 1'b1;
      end
      oc_q <= oc_q + (RES_PW+1)'(res_push) - (RES_PW+1)'(res_pop);
    end
  end

  `SCGS_ASSERT_NEVER(a_res_overflow, clk_i, rst_ni, res_push && !res_pop && (oc_q == (RES_PW+1)'(RES_DEPTH)), "result queue overflow")
  `SCGS_ASSERT(a_wb_after_issue, clk_i, rst_ni, (state_q == ST_SCAT_WB) |-> $past(state_q == ST_IDLE), "scatter writeback without issue")
  `SCGS_ASSERT(a_clear_sweep, clk_i, rst_ni, (state_q == ST_CLEAR && $past(state_q == ST_CLEAR) && $past(rst_ni)) |-> (clr_ptr_q == $past(clr_ptr_q) + 1'b1), "clear pointer skipped")
  `SCGS_ASSERT_NEVER(a_no_cmd_in_init, clk_i, rst_ni, init_q && cmd_pop_o, "command taken during reset clear")

endmodule
`default_nettype wire

// ===== design/sparse_conv_gather_scatter_top.sv =====
// Top level of the sparse conv gather/scatter block: config register,
// front end and back end. Uses scgs_pkg, scgs_front and scgs_back.
//
//  channel   handshake          payload
//  input     push / full        mode_i site_i channel_i value_i batch_end_i
//  result    empty / pop        out_value_o out_channel_o row_last_o list_end_o
//  config    cfg_we_i           cfg_wdata_i (channels_in_use)
//
// Load and read each take one RAM access; scatter-add is a read-modify-write on
// the single gradient RAM port pair; gather makes one feature RAM read per
// channel in use. Clear zeroes all SITES*CHANNELS gradient RAM entries.
// After reset the gradient RAM is swept, all SITES*CHANNELS entries (16384 by
// default), with full held high. A full result queue stalls only the back
// end; the two-entry command queue keeps taking items until it is full.
`default_nettype none
module sparse_conv_gather_scatter_top import scgs_pkg::*; #(
  parameter int SITES    = SITES_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [SITE_W-1:0] site_i,
  input  wire logic [CH_W-1:0]   channel_i,
  input  wire logic [VAL_W-1:0]  value_i,
  input  wire logic              batch_end_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic [VAL_W-1:0]       out_value_o,
  output logic [CH_W-1:0]        out_channel_o,
  output logic                   row_last_o,
  output logic                   list_end_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i
);

  logic [CFG_W-1:0] chan_cfg_q;
  logic [CH_W-1:0]  last_ch;
  logic             cmd_valid, cmd_pop, init_busy;
  cmd_t             cmd;
  res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      chan_cfg_q <= cfg_wdata_i;
    end
  end

  // zero acts as one channel, anything above CHANNELS as CHANNELS
  always_comb begin
    if (chan_cfg_q == '0) begin
      last_ch = '0;
    end else if (32'(chan_cfg_q) > CHANNELS) begin
      last_ch = CH_W'(CHANNELS - 1);
    end else begin
      last_ch = CH_W'(chan_cfg_q - 1'b1);
    end
  end

  scgs_front #(.SITES(SITES), .CHANNELS(CHANNELS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .mode_i      (mode_i),
    .site_i      (site_i),
    .channel_i   (channel_i),
    .value_i     (value_i),
    .batch_end_i (batch_end_i),
    .last_ch_i   (last_ch),
    .hold_i      (init_busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  scgs_back #(.SITES(SITES), .CHANNELS(CHANNELS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .init_busy_o (init_busy),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign out_value_o   = res.value;
  assign out_channel_o = res.channel;
  assign row_last_o    = res.row_last;
  assign list_end_o    = res.list_end;

endmodule
`default_nettype wire
